### rtl/joint_overlimit_fault_debounce_unit_macros.svh
// Assertion macros used by the joint fault debounce merge stage
`ifndef JOINT_OVERLIMIT_FAULT_DEBOUNCE_UNIT_MACROS_SVH
`define JOINT_OVERLIMIT_FAULT_DEBOUNCE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define JOFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("jofd assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define JOFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("jofd assertion failed");

`endif

### rtl/jofd_pkg.sv
// Types and constants of the joint over-limit fault debounce unit
`default_nettype none

package jofd_pkg;

    // Field widths fixed by the sample and result formats
    localparam int NUM_JOINTS = 6;
    localparam int TEMP_W     = 12;
    localparam int CURR_W     = 16;
    localparam int CLIM_W     = 15;
    localparam int ACT_W      = 3;
    localparam int RUN_W      = 3;
    localparam int DUTY_W     = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 15;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIMIT_BASE = 3'd2;

    // Reset values of the configuration registers
    localparam logic [ACT_W-1:0]  ACTIVE_RST     = 3'd6;
    localparam logic [TEMP_W-1:0] TEMP_LIMIT_RST = 12'd600;
    localparam logic [CLIM_W-1:0] CLIMIT_RST     = 15'h7FFF;

    // Buzzer compare value while alarmed
    localparam logic [DUTY_W-1:0] BUZZER_ON_DUTY = 10'd1000;

    // Input word: one sample set
    typedef struct packed {
        logic signed [TEMP_W-1:0] temp_0;
        logic signed [TEMP_W-1:0] temp_1;
        logic signed [TEMP_W-1:0] temp_2;
        logic signed [TEMP_W-1:0] temp_3;
        logic signed [TEMP_W-1:0] temp_4;
        logic signed [TEMP_W-1:0] temp_5;
        logic signed [CURR_W-1:0] current_0;
        logic signed [CURR_W-1:0] current_1;
        logic signed [CURR_W-1:0] current_2;
        logic signed [CURR_W-1:0] current_3;
        logic signed [CURR_W-1:0] current_4;
        logic signed [CURR_W-1:0] current_5;
    } t_in_word;

    // Output word: alarm state for one sample set
    typedef struct packed {
        logic                  alarm;
        logic [DUTY_W-1:0]     buzzer_duty;
        logic [NUM_JOINTS-1:0] temp_fault_mask;
        logic [NUM_JOINTS-1:0] current_fault_mask;
    } t_out_word;

    // Per-lane fault flags after this sample
    typedef struct packed {
        logic temp_hit;
        logic curr_hit;
    } t_lane_hit;

    // Fault masks gathered from all lanes
    typedef struct packed {
        logic [NUM_JOINTS-1:0] temp_mask;
        logic [NUM_JOINTS-1:0] curr_mask;
    } t_hit_masks;

endpackage

`default_nettype wire

### rtl/joint_overlimit_fault_debounce_unit.sv
// Top level of the joint over-limit fault debounce unit
//
//  channel | direction | handshake                    | word
//  --------+-----------+------------------------------+---------------------
//  in      | input     | i_in_valid / o_in_stall      | jofd_pkg::t_in_word
//  out     | output    | o_out_valid / i_out_stall    | jofd_pkg::t_out_word
//  cfg     | input     | i_cfg_we (write only)        | i_cfg_idx, i_cfg_data
//
// One sample set per cycle while the input side does not stall; its result sits in the output
// register from the next cycle. All lanes compare and count in parallel as it is taken.
// Reset (synchronous, active low) clears the run counters and loads the register defaults.
// The input side stalls only while a result waits and the output side stalls.
`default_nettype none

module joint_overlimit_fault_debounce_unit #(
    parameter int JOINTS      = 6,
    parameter int FAULT_COUNT = 5
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_stall,
    input  wire jofd_pkg::t_in_word                   i_in_word,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_stall,
    output jofd_pkg::t_out_word                       o_out_word,
    input  wire logic                                 i_cfg_we,
    input  wire logic [jofd_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  wire logic [jofd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam logic [jofd_pkg::ACT_W-1:0] JOINTS_N = jofd_pkg::ACT_W'(JOINTS);

    logic        [jofd_pkg::ACT_W-1:0]  r_active;
    logic signed [jofd_pkg::TEMP_W-1:0] r_temp_limit;
    logic        [jofd_pkg::CLIM_W-1:0] r_climit [jofd_pkg::NUM_JOINTS];

    logic                               w_ready;
    logic                               w_step;
    logic        [jofd_pkg::ACT_W-1:0]  w_act_n;
    logic signed [jofd_pkg::TEMP_W-1:0] w_temp [jofd_pkg::NUM_JOINTS];
    logic signed [jofd_pkg::CURR_W-1:0] w_curr [jofd_pkg::NUM_JOINTS];
    jofd_pkg::t_lane_hit                w_hit  [jofd_pkg::NUM_JOINTS];
    jofd_pkg::t_hit_masks               w_masks;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active     <= jofd_pkg::ACTIVE_RST;
            r_temp_limit <= jofd_pkg::TEMP_LIMIT_RST;
            for (int k = 0; k < jofd_pkg::NUM_JOINTS; k++) begin
                r_climit[k] <= jofd_pkg::CLIMIT_RST;
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                jofd_pkg::CFG_ACTIVE: begin
                    r_active <= i_cfg_data[jofd_pkg::ACT_W-1:0];
                end
                jofd_pkg::CFG_TEMP_LIMIT: begin
                    r_temp_limit <= i_cfg_data[jofd_pkg::TEMP_W-1:0];
                end
                default: begin
                    r_climit[3'(i_cfg_idx - jofd_pkg::CFG_CLIMIT_BASE)] <= i_cfg_data;
                end
            endcase
        end
    end

    // Take a word whenever the merge stage can hold its result
    assign w_step     = i_in_valid && w_ready;
    assign o_in_stall = !w_ready;

    // Saturate the active count at the number of lanes
    assign w_act_n = (r_active > JOINTS_N) ? JOINTS_N : r_active;

    // Spread the word into per-joint fields
    assign w_temp[0] = i_in_word.temp_0;
    assign w_temp[1] = i_in_word.temp_1;
    assign w_temp[2] = i_in_word.temp_2;
    assign w_temp[3] = i_in_word.temp_3;
    assign w_temp[4] = i_in_word.temp_4;
    assign w_temp[5] = i_in_word.temp_5;
    assign w_curr[0] = i_in_word.current_0;
    assign w_curr[1] = i_in_word.current_1;
    assign w_curr[2] = i_in_word.current_2;
    assign w_curr[3] = i_in_word.current_3;
    assign w_curr[4] = i_in_word.current_4;
    assign w_curr[5] = i_in_word.current_5;

    // Lanes for the built joints; the rest read as fault free
    for (genvar j = 0; j < jofd_pkg::NUM_JOINTS; j++) begin : g_lane
        if (j < JOINTS) begin : g_on
            jofd_lane #(
                .FAULT_COUNT (FAULT_COUNT)
            ) u_lane (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_step       (w_step),
                .i_active     (jofd_pkg::ACT_W'(j) < w_act_n),
                .i_temp       (w_temp[j]),
                .i_current    (w_curr[j]),
                .i_temp_limit (r_temp_limit),
                .i_curr_limit (r_climit[j]),
                .o_hit        (w_hit[j])
            );
        end else begin : g_off
            assign w_hit[j] = '0;
        end
        assign w_masks.temp_mask[j] = w_hit[j].temp_hit;
        assign w_masks.curr_mask[j] = w_hit[j].curr_hit;
    end

    // Merge lane results into the output register
    jofd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_step),
        .i_masks     (w_masks),
        .i_out_stall (i_out_stall),
        .o_ready     (w_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

`default_nettype wire

### rtl/jofd_lane.sv
// One joint lane: limit compares and two saturating run counters
`default_nettype none

module jofd_lane #(
    parameter int FAULT_COUNT = 5
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_step,
    input  wire logic                                i_active,
    input  wire logic signed [jofd_pkg::TEMP_W-1:0]  i_temp,
    input  wire logic signed [jofd_pkg::CURR_W-1:0]  i_current,
    input  wire logic signed [jofd_pkg::TEMP_W-1:0]  i_temp_limit,
    input  wire logic        [jofd_pkg::CLIM_W-1:0]  i_curr_limit,
    output jofd_pkg::t_lane_hit                      o_hit
);

    localparam logic [jofd_pkg::RUN_W-1:0] FC = jofd_pkg::RUN_W'(FAULT_COUNT);

    logic [jofd_pkg::RUN_W-1:0] r_temp_run;
    logic [jofd_pkg::RUN_W-1:0] r_curr_run;
    logic [jofd_pkg::RUN_W-1:0] n_temp_run;
    logic [jofd_pkg::RUN_W-1:0] n_curr_run;
    logic [jofd_pkg::CURR_W:0]  w_cur_ext;
    logic [jofd_pkg::CURR_W:0]  w_mag;
    logic                       w_temp_over;
    logic                       w_curr_over;

    // Compare against limits; magnitude keeps one extra bit for the most negative value
    assign w_cur_ext   = {i_current[jofd_pkg::CURR_W-1], i_current};
    assign w_mag       = i_current[jofd_pkg::CURR_W-1] ? (~w_cur_ext + 1'b1) : w_cur_ext;
    assign w_temp_over = i_temp > i_temp_limit;
    assign w_curr_over = w_mag > {2'b00, i_curr_limit};

    // Advance counters of an active joint: count up to the fault count, clear on a clean sample
    always_comb begin
        n_temp_run = r_temp_run;
        n_curr_run = r_curr_run;
        if (i_active) begin
            if (!w_temp_over) begin
                n_temp_run = '0;
            end else if (r_temp_run < FC) begin
                n_temp_run = r_temp_run + 1'b1;
            end
            if (!w_curr_over) begin
                n_curr_run = '0;
            end else if (r_curr_run < FC) begin
                n_curr_run = r_curr_run + 1'b1;
            end
        end
    end

    // Hold counters unless a word is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_run <= '0;
            r_curr_run <= '0;
        end else if (i_step) begin
            r_temp_run <= n_temp_run;
            r_curr_run <= n_curr_run;
        end
    end

    // Flag faults from the updated counts of an active joint
    assign o_hit.temp_hit = i_active && (n_temp_run >= FC);
    assign o_hit.curr_hit = i_active && (n_curr_run >= FC);

endmodule

`default_nettype wire

### rtl/jofd_merge.sv
// Merge stage: combine lane fault masks into the registered output word
`default_nettype none

`include "joint_overlimit_fault_debounce_unit_macros.svh"

module jofd_merge (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire jofd_pkg::t_hit_masks  i_masks,
    input  wire logic                  i_out_stall,
    output logic                       o_ready,
    output logic                       o_out_valid,
    output jofd_pkg::t_out_word        o_out_word
);

    logic                r_out_valid;
    jofd_pkg::t_out_word r_out_word;
    jofd_pkg::t_out_word n_out_word;
    logic                w_alarm;

    // Open the input side while the output register is empty or draining
    assign o_ready = !r_out_valid || !i_out_stall;

    // Build the result word
    assign w_alarm = (i_masks.temp_mask != '0) || (i_masks.curr_mask != '0);
    always_comb begin
        n_out_word.alarm              = w_alarm;
        n_out_word.buzzer_duty        = w_alarm ? jofd_pkg::BUZZER_ON_DUTY : '0;
        n_out_word.temp_fault_mask    = i_masks.temp_mask;
        n_out_word.current_fault_mask = i_masks.curr_mask;
    end

    // Valid flag: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload register
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_out_word <= n_out_word;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    `JOFD_ASSERT_IMPL(a_alarm_matches_masks, i_clk, i_rst_n, r_out_valid,
                      r_out_word.alarm == ((r_out_word.temp_fault_mask != '0) ||
                                           (r_out_word.current_fault_mask != '0)))
    `JOFD_ASSERT_IMPL(a_duty_follows_alarm, i_clk, i_rst_n, r_out_valid,
                      r_out_word.buzzer_duty ==
                      (r_out_word.alarm ? jofd_pkg::BUZZER_ON_DUTY : '0))
    `JOFD_ASSERT_NEXT(a_load_shows_word, i_clk, i_rst_n, i_load,
                      r_out_valid && (r_out_word.alarm == $past(w_alarm)))

endmodule

`default_nettype wire

### tb/tb_joint_overlimit_fault_debounce_unit.sv
// Self-checking testbench for the joint over-limit fault debounce unit
`timescale 1ns / 100ps

module tb_joint_overlimit_fault_debounce_unit;
    import jofd_pkg::*;

    localparam int RUN_LIMIT    = 5;
    localparam int IDLE_LIMIT   = 1000;
    localparam int WORD_W       = $bits(t_in_word);
    localparam int CURR_TOP     = NUM_JOINTS * CURR_W;
    localparam int PHASES       = 13;
    localparam int PHASE_WORDS  = 98;

    // How a generated value sits against its limit
    typedef enum {LVL_OVER, LVL_EQUAL, LVL_UNDER, LVL_NOISE} t_level;
    // How the per-joint current limits are loaded for a setup
    typedef enum {CLIM_ZERO, CLIM_FULL, CLIM_LOW, CLIM_RANDOM} t_clim_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    joint_overlimit_fault_debounce_unit #(
        .JOINTS      (NUM_JOINTS),
        .FAULT_COUNT (RUN_LIMIT)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the registers and run counters
    logic [ACT_W-1:0]         model_active;
    logic signed [TEMP_W-1:0] model_temp_limit;
    logic [CLIM_W-1:0]        model_climit [NUM_JOINTS];
    logic [RUN_W-1:0]         temp_run [NUM_JOINTS];
    logic [RUN_W-1:0]         curr_run [NUM_JOINTS];

    t_out_word pending_alarm_words [$];
    int        error_count;
    int        samples_sent;
    int        words_checked;
    int        alarm_words;
    int        setups_loaded;
    int        idle_cycles;
    bit        quiet_sides;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Count up while the condition holds, saturate, clear when it drops
    function automatic logic [RUN_W-1:0] advance_run(input logic [RUN_W-1:0] run,
                                                     input bit over);
        if (!over)
            return '0;
        return (run < RUN_LIMIT) ? run + 1'b1 : RUN_W'(RUN_LIMIT);
    endfunction

    // Advance the shadow counters for one sample set and form its alarm word
    function automatic t_out_word debounce_sample(input t_in_word w);
        t_out_word                r;
        logic [WORD_W-1:0]        raw;
        logic signed [TEMP_W-1:0] t;
        logic signed [CURR_W-1:0] c;
        int                       n;
        int                       mag;
        raw = w;
        r   = '0;
        n   = (model_active > NUM_JOINTS) ? NUM_JOINTS : model_active;
        for (int j = 0; j < n; j++) begin
            t   = raw[WORD_W-1-TEMP_W*j -: TEMP_W];
            c   = raw[CURR_TOP-1-CURR_W*j -: CURR_W];
            mag = (c < 0) ? -int'(c) : int'(c);
            temp_run[j] = advance_run(temp_run[j], t > model_temp_limit);
            curr_run[j] = advance_run(curr_run[j], mag > int'(model_climit[j]));
            r.temp_fault_mask[j]    = (temp_run[j] == RUN_LIMIT);
            r.current_fault_mask[j] = (curr_run[j] == RUN_LIMIT);
        end
        r.alarm       = |{r.temp_fault_mask, r.current_fault_mask};
        r.buzzer_duty = r.alarm ? BUZZER_ON_DUTY : '0;
        return r;
    endfunction

    // Same temperature and current on every joint
    function automatic t_in_word same_on_all(input logic [TEMP_W-1:0] t,
                                             input logic [CURR_W-1:0] c);
        logic [WORD_W-1:0] raw;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            raw[WORD_W-1-TEMP_W*j -: TEMP_W]   = t;
            raw[CURR_TOP-1-CURR_W*j -: CURR_W] = c;
        end
        return raw;
    endfunction

    // Pick where a value lands: mostly over with the given share, some edge and noise
    function automatic t_level pick_level(input int over_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return LVL_NOISE;
        if (r < 9)
            return LVL_EQUAL;
        return ($urandom_range(0, 99) < over_pct) ? LVL_OVER : LVL_UNDER;
    endfunction

    // Share of over-limit samples for one joint in a phase
    function automatic int over_share();
        case ($urandom_range(0, 4))
            0:       return 100;
            1:       return 95;
            2:       return 85;
            3:       return 60;
            default: return 15;
        endcase
    endfunction

    // Offer one sample word after a random gap and hold it until taken
    task automatic send_sample(input t_in_word w);
        int gap;
        gap = quiet_sides ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
    endtask

    // Drain, then write every register while the unit is idle
    task automatic load_setup(input logic [CFG_DATA_W-1:0] act_data,
                              input logic [CFG_DATA_W-1:0] temp_data,
                              input t_clim_mode mode);
        logic [CFG_DATA_W-1:0] lim;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_alarm_words.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        write_reg(CFG_ACTIVE, act_data);
        write_reg(CFG_TEMP_LIMIT, temp_data);
        for (int j = 0; j < NUM_JOINTS; j++) begin
            case (mode)
                CLIM_ZERO: lim = '0;
                CLIM_FULL: lim = CFG_DATA_W'(CLIMIT_RST);
                CLIM_LOW:  lim = CFG_DATA_W'($urandom_range(0, 2000));
                default:   lim = CFG_DATA_W'($urandom);
            endcase
            write_reg(CFG_CLIMIT_BASE + CFG_IDX_W'(j), lim);
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        setups_loaded++;
    endtask

    // Reset defaults: strict limits, most negative current, saturation and clear
    task automatic test_reset_defaults();
        repeat (6) send_sample(same_on_all(TEMP_W'(601), CURR_W'(-32768)));
        send_sample(same_on_all(TEMP_LIMIT_RST, CURR_W'(CLIMIT_RST)));
        send_sample(same_on_all(TEMP_W'(2047), CURR_W'(32767)));
        send_sample(same_on_all(TEMP_W'(-2048), '0));
    endtask

    // Active count zero, above the joint count, and held counters of idle joints
    task automatic test_active_count();
        load_setup(CFG_DATA_W'(0), CFG_DATA_W'(TEMP_W'(-2048)), CLIM_ZERO);
        repeat (3) send_sample(same_on_all(TEMP_W'(2047), CURR_W'(1)));
        load_setup(CFG_DATA_W'(7), CFG_DATA_W'(TEMP_W'(-2048)), CLIM_ZERO);
        repeat (5) send_sample(same_on_all(TEMP_W'(-2047), CURR_W'(-1)));
        load_setup(CFG_DATA_W'(3), CFG_DATA_W'(TEMP_W'(2047)), CLIM_ZERO);
        repeat (2) send_sample(same_on_all(TEMP_W'(2047), '0));
        load_setup(CFG_DATA_W'(6), CFG_DATA_W'(TEMP_W'(2047)), CLIM_ZERO);
        repeat (2) send_sample(same_on_all(TEMP_W'(2047), CURR_W'(-32768)));
    endtask

    // Phases of random setups with runs that mostly stay over their limits
    task automatic test_random_phases();
        int                    temp_pct [NUM_JOINTS];
        int                    curr_pct [NUM_JOINTS];
        logic [WORD_W-1:0]     raw;
        logic [CFG_DATA_W-1:0] act_data;
        logic [CFG_DATA_W-1:0] temp_data;
        t_level                lv;
        int                    lim;
        int                    v;
        for (int ph = 0; ph < PHASES; ph++) begin
            quiet_sides = (ph % 3 == 2);
            act_data    = CFG_DATA_W'($urandom);
            if (ph < 8)
                act_data[ACT_W-1:0] = ACT_W'(ph);
            else
                act_data[ACT_W-1:0] = ($urandom_range(0, 2) == 0) ?
                                      ACT_W'($urandom_range(0, 7)) : ACT_W'(6);
            temp_data = CFG_DATA_W'($urandom);
            case (ph % 5)
                0:       temp_data[TEMP_W-1:0] = TEMP_W'(-2048);
                1:       temp_data[TEMP_W-1:0] = TEMP_W'(2047);
                default: temp_data[TEMP_W-1:0] = TEMP_W'(-400 + int'($urandom_range(0, 1900)));
            endcase
            load_setup(act_data, temp_data, t_clim_mode'(ph % 4));
            for (int j = 0; j < NUM_JOINTS; j++) begin
                temp_pct[j] = over_share();
                curr_pct[j] = over_share();
            end
            for (int k = 0; k < PHASE_WORDS; k++) begin
                for (int j = 0; j < NUM_JOINTS; j++) begin
                    // Temperature against the shared limit
                    lv  = pick_level(temp_pct[j]);
                    lim = model_temp_limit;
                    case (lv)
                        LVL_OVER:  v = (lim < 2047) ?
                                       lim + 1 + int'($urandom_range(0, 2046 - lim)) : lim;
                        LVL_EQUAL: v = lim;
                        LVL_UNDER: v = (lim > -2048) ?
                                       -2048 + int'($urandom_range(0, lim + 2047)) : lim;
                        default:   v = $urandom;
                    endcase
                    raw[WORD_W-1-TEMP_W*j -: TEMP_W] = TEMP_W'(v);
                    // Current magnitude against this joint's limit, random sign
                    lv  = pick_level(curr_pct[j]);
                    lim = model_climit[j];
                    case (lv)
                        LVL_OVER:  v = lim + 1 + int'($urandom_range(0, 32767 - lim));
                        LVL_EQUAL: v = lim;
                        LVL_UNDER: v = (lim > 0) ? int'($urandom_range(0, lim - 1)) : lim;
                        default:   v = $urandom;
                    endcase
                    if (lv != LVL_NOISE && $urandom_range(0, 1) == 1)
                        v = -v;
                    raw[CURR_TOP-1-CURR_W*j -: CURR_W] = CURR_W'(v);
                end
                send_sample(raw);
            end
        end
        quiet_sides = 1'b0;
    endtask

    // Result side: random stall before each word, none in quiet stretches
    initial begin
        int hold;
        i_out_stall <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            hold = quiet_sides ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Check each result word against the oldest prediction, then take new samples
    always @(posedge i_clk) begin : alarm_checker
        t_out_word want;
        bit        moved;
        if (i_rst_n) begin
            moved = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                moved = 1'b1;
                if (pending_alarm_words.size() == 0) begin
                    $error("alarm word with no sample set pending");
                    error_count++;
                end else begin
                    want = pending_alarm_words.pop_front();
                    if (o_out_word.alarm !== want.alarm) begin
                        $error("alarm: expected %0d, got %0d", want.alarm, o_out_word.alarm);
                        error_count++;
                    end
                    if (o_out_word.buzzer_duty !== want.buzzer_duty) begin
                        $error("buzzer_duty: expected %0d, got %0d",
                               want.buzzer_duty, o_out_word.buzzer_duty);
                        error_count++;
                    end
                    if (o_out_word.temp_fault_mask !== want.temp_fault_mask) begin
                        $error("temp_fault_mask: expected %b, got %b",
                               want.temp_fault_mask, o_out_word.temp_fault_mask);
                        error_count++;
                    end
                    if (o_out_word.current_fault_mask !== want.current_fault_mask) begin
                        $error("current_fault_mask: expected %b, got %b",
                               want.current_fault_mask, o_out_word.current_fault_mask);
                        error_count++;
                    end
                    words_checked++;
                    if (want.alarm)
                        alarm_words++;
                end
            end
            // Mirror register writes
            if (i_cfg_we) begin
                moved = 1'b1;
                if (i_cfg_idx == CFG_ACTIVE)
                    model_active = i_cfg_data[ACT_W-1:0];
                else if (i_cfg_idx == CFG_TEMP_LIMIT)
                    model_temp_limit = i_cfg_data[TEMP_W-1:0];
                else
                    model_climit[i_cfg_idx - CFG_CLIMIT_BASE] = i_cfg_data[CLIM_W-1:0];
            end
            if (i_in_valid && !o_in_stall) begin
                moved = 1'b1;
                pending_alarm_words.push_back(debounce_sample(i_in_word));
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        do @(posedge i_clk); while (idle_cycles < IDLE_LIMIT);
        $display("tb_joint_overlimit_fault_debounce_unit failed");
        $finish;
    end

    // Test sequence
    initial begin
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_word  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        error_count   = 0;
        samples_sent  = 0;
        words_checked = 0;
        alarm_words   = 0;
        setups_loaded = 0;
        idle_cycles   = 0;
        quiet_sides   = 1'b0;
        model_active     = ACTIVE_RST;
        model_temp_limit = TEMP_LIMIT_RST;
        for (int j = 0; j < NUM_JOINTS; j++) begin
            model_climit[j] = CLIMIT_RST;
            temp_run[j]     = '0;
            curr_run[j]     = '0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_active_count();
        test_random_phases();

        // Drain and let the output register settle
        i_in_valid <= 1'b0;
        while (pending_alarm_words.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("Sent %0d sample sets under %0d register setups;", samples_sent, setups_loaded);
        $display("checked %0d result words, %0d alarmed, over active counts 0 to 7,",
                 words_checked, alarm_words);
        $display("limit extremes, equal-to-limit values and random stalls.");
        if (error_count == 0)
            $display("tb_joint_overlimit_fault_debounce_unit passed");
        else
            $display("tb_joint_overlimit_fault_debounce_unit failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/jofd_pkg.sv
rtl/jofd_lane.sv
rtl/jofd_merge.sv
rtl/joint_overlimit_fault_debounce_unit.sv
tb/tb_joint_overlimit_fault_debounce_unit.sv
